@@ rtl/pid_deadband_antiwindup_macros.svh @@
// ----------------------------------------------------------------------------
// pid_deadband_antiwindup_macros
// assertion helpers used by the controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_DEADBAND_ANTIWINDUP_MACROS_SVH
`define PID_DEADBAND_ANTIWINDUP_MACROS_SVH

// same-cycle implication, quiet during reset
`define PDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pda assertion failed");

// next-cycle implication, quiet during reset
`define PDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pda assertion failed");

`endif

@@ rtl/pda_pkg.sv @@
// ----------------------------------------------------------------------------
// pda_pkg
// types and register codes of the deadband pid controller
// ----------------------------------------------------------------------------
package pda_pkg;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ERR,
      ST_P_START,
      ST_P_DONE,
      ST_A_DONE,
      ST_G_START,
      ST_G_DONE,
      ST_BC_DONE,
      ST_D_START,
      ST_DV_DONE,
      ST_DM_START,
      ST_D_DONE,
      ST_CLAMP,
      ST_FIN,
      ST_MUL_RUN,
      ST_MUL_NEG,
      ST_DIV_RUN,
      ST_DIV_NEG
   } state_type;

   // register indexes
   localparam logic [2:0] CSR_GAIN_P     = 3'd0;
   localparam logic [2:0] CSR_GAIN_I     = 3'd1;
   localparam logic [2:0] CSR_GAIN_D     = 3'd2;
   localparam logic [2:0] CSR_LIMIT_LOW  = 3'd3;
   localparam logic [2:0] CSR_LIMIT_HIGH = 3'd4;
   localparam logic [2:0] CSR_DEAD_ZONE  = 3'd5;

   // serial unit step count minus one
   localparam logic [5:0] SERIAL_LAST = 6'd48;

endpackage

@@ rtl/pid_deadband_antiwindup.sv @@
// ----------------------------------------------------------------------------
// pid_deadband_antiwindup
// q16.16 pid step with error deadband, integral clamp and output clamp
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| kind, target, measured, step_time
//  rsp     | out       | rsp_valid/rsp_stall| drive
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// a compute word holds the input while four 49-step shift-add multiplies
// and one or two 49-step restoring divides run, each plus a sign step;
// the second divide runs only when the integral is written back. clear words
// and words with a non-positive step go straight to output. reset (synchronous)
// clears integral, last error and gains and presets limits and dead zone.
// a finished result waits in the output register; the sequencer holds
// only if a new result is ready while the previous one is still stalled.
// ----------------------------------------------------------------------------
`include "pid_deadband_antiwindup_macros.svh"

module pid_deadband_antiwindup (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_measured,
   input  logic signed [31:0] req_step_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // magnitude helpers
   function automatic logic [32:0] mag_32(input logic signed [31:0] v);
      logic signed [32:0] w;
      begin
         w = 33'(v);
         mag_32 = w[32] ? 33'(-w) : 33'(w);
      end
   endfunction

   function automatic logic [48:0] mag_48(input logic signed [47:0] v);
      logic signed [48:0] w;
      begin
         w = 49'(v);
         mag_48 = w[48] ? 49'(-w) : 49'(w);
      end
   endfunction

   function automatic logic [49:0] mag_50(input logic signed [49:0] v);
      mag_50 = v[49] ? 50'(-v) : 50'(v);
   endfunction

   pda_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic signed [31:0] gp_ff, gp_in, gi_ff, gi_in, gd_ff, gd_in;
   logic signed [31:0] ll_ff, ll_in, lh_ff, lh_in;
   logic [30:0]        dz_ff, dz_in;

   logic signed [32:0] e_ff, e_in;
   logic signed [31:0] dt_ff, dt_in, err_ff, err_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [31:0] last_ff, last_in;
   logic signed [47:0] p_ff, p_in;
   logic signed [31:0] it_ff, it_in, dv_ff, dv_in;
   logic signed [49:0] y_ff, y_in;
   logic signed [31:0] res_ff, res_in, drive_ff, drive_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [32:0]        ma_ff, ma_in;
   logic [81:0]        prod_ff, prod_in;
   logic               mneg_ff, mneg_in;
   logic signed [66:0] mq_ff, mq_in;
   logic [31:0]        dd_ff, dd_in, dr_ff, dr_in;
   logic [48:0]        dqr_ff, dqr_in;
   logic               dneg_ff, dneg_in;
   logic signed [49:0] dq_ff, dq_in;
   logic [5:0]         cnt_ff, cnt_in;

   logic               req_accept, out_free, hi_over, lo_under;

   assign req_stall  = (state_ff != pda_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = drive_ff;
   assign hi_over    = mq_ff > 67'(lh_ff);
   assign lo_under   = mq_ff < 67'(ll_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         pda_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_kind || req_step_time <= 32'sd0) state_in = pda_pkg::ST_FIN;
               else state_in = pda_pkg::ST_ERR;
            end
         end
         pda_pkg::ST_ERR:     state_in = pda_pkg::ST_P_START;
         pda_pkg::ST_P_START: begin
            state_in = pda_pkg::ST_MUL_RUN;
            ret_in   = pda_pkg::ST_P_DONE;
         end
         pda_pkg::ST_P_DONE: begin
            state_in = pda_pkg::ST_MUL_RUN;
            ret_in   = pda_pkg::ST_A_DONE;
         end
         pda_pkg::ST_A_DONE:  state_in = pda_pkg::ST_G_START;
         pda_pkg::ST_G_START: begin
            state_in = pda_pkg::ST_MUL_RUN;
            ret_in   = pda_pkg::ST_G_DONE;
         end
         pda_pkg::ST_G_DONE: begin
            if ((hi_over || lo_under) && gi_ff != 32'sd0) begin
               state_in = pda_pkg::ST_DIV_RUN;
               ret_in   = pda_pkg::ST_BC_DONE;
            end else begin
               state_in = pda_pkg::ST_D_START;
            end
         end
         pda_pkg::ST_BC_DONE: state_in = pda_pkg::ST_D_START;
         pda_pkg::ST_D_START: begin
            state_in = pda_pkg::ST_DIV_RUN;
            ret_in   = pda_pkg::ST_DV_DONE;
         end
         pda_pkg::ST_DV_DONE:  state_in = pda_pkg::ST_DM_START;
         pda_pkg::ST_DM_START: begin
            state_in = pda_pkg::ST_MUL_RUN;
            ret_in   = pda_pkg::ST_D_DONE;
         end
         pda_pkg::ST_D_DONE: state_in = pda_pkg::ST_CLAMP;
         pda_pkg::ST_CLAMP:  state_in = pda_pkg::ST_FIN;
         pda_pkg::ST_FIN: begin
            if (out_free) state_in = pda_pkg::ST_IDLE;
         end
         pda_pkg::ST_MUL_RUN: begin
            if (cnt_ff == 6'd0) state_in = pda_pkg::ST_MUL_NEG;
         end
         pda_pkg::ST_MUL_NEG: state_in = ret_ff;
         pda_pkg::ST_DIV_RUN: begin
            if (cnt_ff == 6'd0) state_in = pda_pkg::ST_DIV_NEG;
         end
         pda_pkg::ST_DIV_NEG: state_in = ret_ff;
         default:             state_in = pda_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      logic signed [33:0] e34, pos, negv, sh;
      logic signed [48:0] asum;
      logic signed [49:0] yc, num;
      logic               mul_go, div_go;
      logic signed [31:0] mul_a, div_den;
      logic signed [47:0] mul_b;
      logic [32:0]        rs;
      logic [81:0]        pmag;
      logic [33:0]        psum;
      logic signed [82:0] ps;

      gp_in = gp_ff;  gi_in = gi_ff;  gd_in = gd_ff;
      ll_in = ll_ff;  lh_in = lh_ff;  dz_in = dz_ff;
      e_in = e_ff;    dt_in = dt_ff;  err_in = err_ff;
      acc_in = acc_ff; last_in = last_ff;
      p_in = p_ff;    it_in = it_ff;  dv_in = dv_ff;
      y_in = y_ff;    res_in = res_ff; drive_in = drive_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ma_in = ma_ff;  prod_in = prod_ff; mneg_in = mneg_ff; mq_in = mq_ff;
      dd_in = dd_ff;  dr_in = dr_ff;  dqr_in = dqr_ff; dneg_in = dneg_ff;
      dq_in = dq_ff;  cnt_in = cnt_ff;
      mul_go = 1'b0;  mul_a = gp_ff;  mul_b = 48'(err_ff);
      div_go = 1'b0;  div_den = dt_ff; num = '0;
      e34 = 34'(e_ff);
      pos = e34 - 34'(dz_ff);
      negv = e34 + 34'(dz_ff);
      sh = '0;
      asum = 49'(acc_ff) + 49'($signed(mq_ff[47:0]));
      yc = '0;
      rs = {dr_ff, dqr_ff[48]};
      pmag = '0;
      psum = 34'(prod_ff[81:49]) + (prod_ff[0] ? 34'(ma_ff) : 34'd0);
      ps = '0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            pda_pkg::CSR_GAIN_P:     gp_in = $signed(csr_wdata);
            pda_pkg::CSR_GAIN_I:     gi_in = $signed(csr_wdata);
            pda_pkg::CSR_GAIN_D:     gd_in = $signed(csr_wdata);
            pda_pkg::CSR_LIMIT_LOW:  ll_in = $signed(csr_wdata);
            pda_pkg::CSR_LIMIT_HIGH: lh_in = $signed(csr_wdata);
            pda_pkg::CSR_DEAD_ZONE:  dz_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         pda_pkg::ST_IDLE: begin
            if (req_accept) begin
               e_in   = 33'(req_target) - 33'(req_measured);
               dt_in  = req_step_time;
               res_in = '0;
               if (req_kind) begin
                  acc_in  = '0;
                  last_in = '0;
               end
            end
         end
         // deadband and saturation of the error
         pda_pkg::ST_ERR: begin
            if (!e_ff[32]) sh = pos[33] ? 34'sd0 : pos;
            else sh = negv[33] ? negv : 34'sd0;
            if (sh > 34'sd2147483647) err_in = 32'sh7fffffff;
            else if (sh < -34'sd2147483648) err_in = 32'sh80000000;
            else err_in = sh[31:0];
         end
         pda_pkg::ST_P_START: begin
            mul_go = 1'b1;
            mul_a  = gp_ff;
            mul_b  = 48'(err_ff);
         end
         pda_pkg::ST_P_DONE: begin
            p_in   = $signed(mq_ff[47:0]);
            mul_go = 1'b1;
            mul_a  = err_ff;
            mul_b  = 48'(dt_ff);
         end
         // saturating integral update
         pda_pkg::ST_A_DONE: begin
            if (asum > 49'sh0_7fff_ffff_ffff) acc_in = 48'sh7fff_ffff_ffff;
            else if (asum < -49'sh0_8000_0000_0000) acc_in = 48'sh8000_0000_0000;
            else acc_in = asum[47:0];
         end
         pda_pkg::ST_G_START: begin
            mul_go = 1'b1;
            mul_a  = gi_ff;
            mul_b  = acc_ff;
         end
         // integral term clamp with back-calculation
         pda_pkg::ST_G_DONE: begin
            if (hi_over) begin
               it_in   = lh_ff;
               num     = 50'(lh_ff) <<< 16;
               div_den = gi_ff;
               div_go  = (gi_ff != 32'sd0);
            end else if (lo_under) begin
               it_in   = ll_ff;
               num     = 50'(ll_ff) <<< 16;
               div_den = gi_ff;
               div_go  = (gi_ff != 32'sd0);
            end else begin
               it_in = mq_ff[31:0];
            end
         end
         pda_pkg::ST_BC_DONE: begin
            if (dq_ff > 50'sh0_7fff_ffff_ffff) acc_in = 48'sh7fff_ffff_ffff;
            else if (dq_ff < -50'sh0_8000_0000_0000) acc_in = 48'sh8000_0000_0000;
            else acc_in = dq_ff[47:0];
         end
         pda_pkg::ST_D_START: begin
            num     = (50'(err_ff) - 50'(last_ff)) <<< 16;
            div_den = dt_ff;
            div_go  = 1'b1;
            last_in = err_ff;
         end
         pda_pkg::ST_DV_DONE: begin
            if (dq_ff > 50'sd2147483647) dv_in = 32'sh7fffffff;
            else if (dq_ff < -50'sd2147483648) dv_in = 32'sh80000000;
            else dv_in = dq_ff[31:0];
         end
         pda_pkg::ST_DM_START: begin
            mul_go = 1'b1;
            mul_a  = gd_ff;
            mul_b  = 48'(dv_ff);
         end
         pda_pkg::ST_D_DONE: begin
            y_in = 50'(p_ff) + 50'(it_ff) + 50'($signed(mq_ff[47:0]));
         end
         // output clamp, high limit first
         pda_pkg::ST_CLAMP: begin
            yc = (y_ff > 50'(lh_ff)) ? 50'(lh_ff) : y_ff;
            if (yc < 50'(ll_ff)) yc = 50'(ll_ff);
            res_in = yc[31:0];
         end
         pda_pkg::ST_FIN: begin
            if (out_free) begin
               drive_in     = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         // one shift-add step of the multiplier
         pda_pkg::ST_MUL_RUN: begin
            prod_in = {psum, prod_ff[48:1]};
            cnt_in  = cnt_ff - 6'd1;
         end
         pda_pkg::ST_MUL_NEG: begin
            pmag  = prod_ff;
            ps    = mneg_ff ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
            mq_in = ps[82:16];
         end
         // one restoring step of the divider
         pda_pkg::ST_DIV_RUN: begin
            if (rs >= {1'b0, dd_ff}) begin
               dr_in  = 32'(rs - {1'b0, dd_ff});
               dqr_in = {dqr_ff[47:0], 1'b1};
            end else begin
               dr_in  = rs[31:0];
               dqr_in = {dqr_ff[47:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
         pda_pkg::ST_DIV_NEG: begin
            dq_in = dneg_ff ? -$signed({1'b0, dqr_ff}) : $signed({1'b0, dqr_ff});
         end
         default: ;
      endcase

      // load the serial multiplier
      if (mul_go) begin
         ma_in   = mag_32(mul_a);
         prod_in = {33'd0, mag_48(mul_b)};
         mneg_in = mul_a[31] ^ mul_b[47];
         cnt_in  = pda_pkg::SERIAL_LAST;
      end

      // load the serial divider
      if (div_go) begin
         dd_in   = 32'(mag_32(div_den));
         dqr_in  = 49'(mag_50(num));
         dr_in   = '0;
         dneg_in = num[49] ^ div_den[31];
         cnt_in  = pda_pkg::SERIAL_LAST;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pda_pkg::ST_IDLE;
         ret_ff       <= pda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gp_ff        <= '0;
         gi_ff        <= '0;
         gd_ff        <= '0;
         ll_ff        <= -32'sd655360;
         lh_ff        <= 32'sd655360;
         dz_ff        <= 31'd1311;
         acc_ff       <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         gp_ff        <= gp_in;
         gi_ff        <= gi_in;
         gd_ff        <= gd_in;
         ll_ff        <= ll_in;
         lh_ff        <= lh_in;
         dz_ff        <= dz_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      dt_ff    <= dt_in;
      err_ff   <= err_in;
      p_ff     <= p_in;
      it_ff    <= it_in;
      dv_ff    <= dv_in;
      y_ff     <= y_in;
      res_ff   <= res_in;
      drive_ff <= drive_in;
      ma_ff    <= ma_in;
      prod_ff  <= prod_in;
      mneg_ff  <= mneg_in;
      mq_ff    <= mq_in;
      dd_ff    <= dd_in;
      dr_ff    <= dr_in;
      dqr_ff   <= dqr_in;
      dneg_ff  <= dneg_in;
      dq_ff    <= dq_in;
   end

   // checks
   `PDA_ASSERT_NEXT(a_clear_state, clock, reset, req_accept && req_kind,
                    acc_ff == 48'sd0 && last_ff == 32'sd0)
   `PDA_ASSERT_NEXT(a_bad_step_keeps, clock, reset,
                    req_accept && !req_kind && req_step_time <= 32'sd0,
                    acc_ff == $past(acc_ff) && last_ff == $past(last_ff))
   `PDA_ASSERT_NEXT(a_mul_runs, clock, reset,
                    state_ff == pda_pkg::ST_MUL_RUN && cnt_ff != 6'd0,
                    state_ff == pda_pkg::ST_MUL_RUN)
   `PDA_ASSERT_NEXT(a_fin_delivers, clock, reset,
                    state_ff == pda_pkg::ST_FIN && out_free,
                    rsp_valid && state_ff == pda_pkg::ST_IDLE)

endmodule

@@ tb/sv/tb_pid_deadband_antiwindup.sv @@
// ----------------------------------------------------------------------------
// tb_pid_deadband_antiwindup
// self-checking bench for the deadband pid controller: directed corner words,
// several register settings and random control loops, each result compared
// against an in-bench fixed point predictor of the controller step
// ----------------------------------------------------------------------------
module tb_pid_deadband_antiwindup;

   localparam longint I48_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint I48_MIN = -I48_MAX - 1;
   localparam longint I32_MAX = 64'sh7FFF_FFFF;
   localparam longint I32_MIN = -I32_MAX - 1;
   localparam int     LIMIT_CYCLES = 900000;
   localparam int     SETTLE_CYCLES = 300;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic signed [31:0] req_target;
   logic signed [31:0] req_measured;
   logic signed [31:0] req_step_time;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_drive;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   // predictor copy of registers and state
   longint kp, ki, kd, lim_lo, lim_hi, dzone;
   longint integ, prev_err;

   logic signed [31:0] drive_q[$];
   int errors;
   int cycles;
   bit quiet;
   bit hold_rsp;

   pid_deadband_antiwindup i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_target(req_target), .req_measured(req_measured),
      .req_step_time(req_step_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_drive(rsp_drive),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint floor16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // exact (g * x) >> 16 for a 48 bit x
   function automatic longint gain_mul(longint g, longint x);
      longint h;
      longint l;
      h = floor16(x);
      l = x - h * 65536;
      return g * h + floor16(g * l);
   endfunction

   // one controller step, returns the expected drive
   function automatic logic signed [31:0] pid_step(logic kind, logic signed [31:0] tg,
         logic signed [31:0] ms, logic signed [31:0] st);
      longint e, mag, p, it, dv, d, y, dt;
      if (kind) begin
         integ = 0;
         prev_err = 0;
         return 32'sd0;
      end
      dt = st;
      if (dt <= 0) return 32'sd0;
      e = longint'(tg) - longint'(ms);
      mag = e < 0 ? -e : e;
      if (mag < dzone) e = 0;
      else if (e > 0) e = e - dzone;
      else e = e + dzone;
      e = clip(e, I32_MIN, I32_MAX);
      p = floor16(kp * e);
      integ = clip(integ + floor16(e * dt), I48_MIN, I48_MAX);
      it = gain_mul(ki, integ);
      if (it > lim_hi) begin
         it = lim_hi;
         if (ki != 0) integ = clip((it * 65536) / ki, I48_MIN, I48_MAX);
      end else if (it < lim_lo) begin
         it = lim_lo;
         if (ki != 0) integ = clip((it * 65536) / ki, I48_MIN, I48_MAX);
      end
      dv = clip(((e - prev_err) * 65536) / dt, I32_MIN, I32_MAX);
      d = floor16(kd * dv);
      prev_err = e;
      y = p + it + d;
      if (y > lim_hi) y = lim_hi;
      if (y < lim_lo) y = lim_lo;
      return y[31:0];
   endfunction

   task automatic report_mismatch(string what, logic signed [31:0] got,
         logic signed [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task automatic report_mismatch_if(logic signed [31:0] got, logic signed [31:0] want);
      if (got !== want) report_mismatch("drive", got, want);
   endtask

   // timeout counter
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) report_mismatch("unexpected word", rsp_drive, 32'sd0);
         else report_mismatch_if(rsp_drive, drive_q.pop_front());
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      int n;
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (!quiet && $urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 13);
         rsp_stall <= 1'b1;
         repeat (n) @(negedge clock);
         rsp_stall <= 1'b0;
      end else rsp_stall <= 1'b0;
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         pda_pkg::CSR_GAIN_P:     kp = longint'($signed(val));
         pda_pkg::CSR_GAIN_I:     ki = longint'($signed(val));
         pda_pkg::CSR_GAIN_D:     kd = longint'($signed(val));
         pda_pkg::CSR_LIMIT_LOW:  lim_lo = longint'($signed(val));
         pda_pkg::CSR_LIMIT_HIGH: lim_hi = longint'($signed(val));
         pda_pkg::CSR_DEAD_ZONE:  dzone = longint'(val[30:0]);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // send one word, predicting at acceptance; valid stays up until the
   // next word or an idle gap replaces it
   task automatic send_word(logic kind, logic signed [31:0] tg, logic signed [31:0] ms,
         logic signed [31:0] st);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_target <= tg;
      req_measured <= ms;
      req_step_time <= st;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      drive_q.push_back(pid_step(kind, tg, ms, st));
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rnd_small();
      return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
   endfunction

   task automatic test_directed();
      write_reg(pda_pkg::CSR_GAIN_P, 32'sd65536);
      write_reg(pda_pkg::CSR_GAIN_I, 32'sd32768);
      write_reg(pda_pkg::CSR_GAIN_D, 32'sd6554);
      send_word(1'b0, 32'sd65536, 32'sd0, 32'sd6554);
      send_word(1'b0, 32'sd1000, 32'sd0, 32'sd6554);           // inside deadband
      send_word(1'b0, -32'sd1311, 32'sd0, 32'sd6554);          // on the deadband edge
      send_word(1'b0, 32'sd65536, 32'sd0, 32'sd0);             // zero step
      send_word(1'b0, 32'sd65536, 32'sd0, 32'h8000_0000);      // negative step
      send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd1);   // error overflows
      send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // clear
      send_word(1'b0, 32'sd0, 32'sd655360, 32'sd65536);
      send_word(1'b0, 32'sd0, 32'sd0, 32'sd1);
      wait_idle();
      // zero integral gain keeps the integral, inverted limits, max values
      write_reg(pda_pkg::CSR_GAIN_I, 32'sd0);
      write_reg(pda_pkg::CSR_LIMIT_LOW, 32'sd65536);
      write_reg(pda_pkg::CSR_LIMIT_HIGH, -32'sd65536);
      write_reg(pda_pkg::CSR_DEAD_ZONE, 32'hFFFF_FFFF);
      send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd65536);
      wait_idle();
      write_reg(3'd7, 32'h1234_5678);                          // unused index
      write_reg(pda_pkg::CSR_DEAD_ZONE, 32'sd0);
      write_reg(pda_pkg::CSR_GAIN_P, 32'h8000_0000);
      write_reg(pda_pkg::CSR_GAIN_I, 32'h7FFF_FFFF);
      write_reg(pda_pkg::CSR_GAIN_D, 32'h8000_0000);
      write_reg(pda_pkg::CSR_LIMIT_LOW, 32'h8000_0000);
      write_reg(pda_pkg::CSR_LIMIT_HIGH, 32'h7FFF_FFFF);
      for (int k = 0; k < 6; k++)
         send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd1);
      wait_idle();
   endtask

   // random loops under one register setting
   task automatic test_random_phase(int words, bit wide);
      logic signed [31:0] tg, ms, st;
      tg = rnd_small();
      for (int k = 0; k < words; k++) begin
         if ($urandom_range(0, 9) == 0) tg = wide ? $signed($urandom) : rnd_small();
         ms = wide ? $signed($urandom) : rnd_small();
         st = $urandom_range(0, 7) == 0 ? $signed($urandom)
                                        : $signed($urandom_range(1, 1 << 17));
         send_word($urandom_range(0, 24) == 0, tg, ms, st);
      end
      wait_idle();
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(pda_pkg::CSR_GAIN_P, ph[0] ? $urandom : $urandom_range(0, 4 << 16));
         write_reg(pda_pkg::CSR_GAIN_I,
                   ph == 3 ? 32'd0 : (ph[1] ? $urandom : $urandom_range(0, 2 << 16)));
         write_reg(pda_pkg::CSR_GAIN_D, ph[2] ? $urandom : $urandom_range(0, 1 << 15));
         write_reg(pda_pkg::CSR_LIMIT_LOW,
                   ph == 5 ? $urandom : -$urandom_range(1 << 16, 20 << 16));
         write_reg(pda_pkg::CSR_LIMIT_HIGH,
                   ph == 5 ? $urandom : $urandom_range(1 << 16, 20 << 16));
         write_reg(pda_pkg::CSR_DEAD_ZONE, ph == 6 ? $urandom : $urandom_range(0, 4000));
         test_random_phase(55, ph >= 4);
      end
   endtask

   // receiver holds off long while words keep coming
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (1500) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 6; k++) send_word(1'b0, rnd_small(), rnd_small(), 32'sd6554);
      join
      wait_idle();
   endtask

   task automatic test_no_idle();
      quiet = 1'b1;
      test_random_phase(40, 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = 1'b0;
      req_target = '0;
      req_measured = '0;
      req_step_time = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      cycles = 0;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      kp = 0; ki = 0; kd = 0;
      lim_lo = -655360; lim_hi = 655360; dzone = 1311;
      integ = 0; prev_err = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_random();
      test_backpressure();
      test_no_idle();
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
